// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top module of the stop-and-light sequencer.
// No dependencies; take in by `include inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside of reset.
`define SLMS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that the consequent holds on the next edge after the antecedent, outside of reset.
`define SLMS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/slms_pkg.sv =====
// Types and constants of the stop-and-light mode sequencer.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package slms_pkg;

    // Mode codes of the planner
    localparam logic [3:0] MODE_DRIVING      = 4'd0;
    localparam logic [3:0] MODE_TL_NEAR      = 4'd1;
    localparam logic [3:0] MODE_TL_GO        = 4'd2;
    localparam logic [3:0] MODE_TL_WILL_STOP = 4'd3;
    localparam logic [3:0] MODE_TL_SLOW_DOWN = 4'd4;
    localparam logic [3:0] MODE_TL_WAITING   = 4'd5;
    localparam logic [3:0] MODE_ST_NEAR      = 4'd6;
    localparam logic [3:0] MODE_ST_WILL_STOP = 4'd7;
    localparam logic [3:0] MODE_ST_WAITING   = 4'd8;
    localparam logic [3:0] MODE_ST_GO        = 4'd9;

    // Light colour codes
    localparam logic [1:0] COLOUR_UNKNOWN = 2'd0;
    localparam logic [1:0] COLOUR_RED     = 2'd1;
    localparam logic [1:0] COLOUR_YELLOW  = 2'd2;
    localparam logic [1:0] COLOUR_GREEN   = 2'd3;

    // Configuration register indexes
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] CFG_IGNORE_TRAFFIC_RULES = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LEAVE_GO_SPEED       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_STANDSTILL_SPEED     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_STOP_LINE_GAP    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_STOP_WAIT_MS         = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_EMERGENCY_EXIT_MS    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_STOP_GO_HOLD_MS      = 3'd6;

    // Reset values of the configuration registers
    localparam logic [14:0] RST_LEAVE_GO_SPEED    = 15'd100;
    localparam logic [14:0] RST_STANDSTILL_SPEED  = 15'd10;
    localparam logic [15:0] RST_MIN_STOP_LINE_GAP = 16'd200;
    localparam logic [31:0] RST_STOP_WAIT_MS      = 32'd3000;
    localparam logic [31:0] RST_EMERGENCY_EXIT_MS = 32'd10000;
    localparam logic [31:0] RST_STOP_GO_HOLD_MS   = 32'd2000;

    typedef struct packed {
        logic        ignore_traffic_rules;
        logic [14:0] leave_go_speed;
        logic [14:0] standstill_speed;
        logic [15:0] min_stop_line_gap;
        logic [31:0] stop_wait_ms;
        logic [31:0] emergency_exit_ms;
        logic [31:0] stop_go_hold_ms;
    } t_cfg;

    typedef struct packed {
        logic               light_seen;
        logic               stop_seen;
        logic [1:0]         light_colour;
        logic [15:0]        braking_distance;
        logic signed [15:0] speed;
        logic [15:0]        stop_line_distance;
        logic               crossing_clear;
        logic [31:0]        now_ms;
    } t_in_item;

    typedef struct packed {
        logic [3:0] mode;
        logic       in_light_group;
        logic       in_stop_group;
        logic       mode_changed;
    } t_out_item;

endpackage

// ===== rtl/core/slms_cfg_regs.sv =====
// Configuration register file of the stop-and-light mode sequencer.
// Depends on slms_pkg for the register indexes, reset values and t_cfg.
`timescale 1ns / 1ps

module slms_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [slms_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [slms_pkg::CFG_DATA_W-1:0]  i_cfg_wr_data,
    output slms_pkg::t_cfg                   o_cfg
);
    import slms_pkg::*;

    t_cfg r_cfg;

    // Reset to the defaults, else write the addressed register; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ignore_traffic_rules <= 1'b0;
            r_cfg.leave_go_speed       <= RST_LEAVE_GO_SPEED;
            r_cfg.standstill_speed     <= RST_STANDSTILL_SPEED;
            r_cfg.min_stop_line_gap    <= RST_MIN_STOP_LINE_GAP;
            r_cfg.stop_wait_ms         <= RST_STOP_WAIT_MS;
            r_cfg.emergency_exit_ms    <= RST_EMERGENCY_EXIT_MS;
            r_cfg.stop_go_hold_ms      <= RST_STOP_GO_HOLD_MS;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_IGNORE_TRAFFIC_RULES: r_cfg.ignore_traffic_rules <= i_cfg_wr_data[0];
                CFG_LEAVE_GO_SPEED:       r_cfg.leave_go_speed       <= i_cfg_wr_data[14:0];
                CFG_STANDSTILL_SPEED:     r_cfg.standstill_speed     <= i_cfg_wr_data[14:0];
                CFG_MIN_STOP_LINE_GAP:    r_cfg.min_stop_line_gap    <= i_cfg_wr_data[15:0];
                CFG_STOP_WAIT_MS:         r_cfg.stop_wait_ms         <= i_cfg_wr_data;
                CFG_EMERGENCY_EXIT_MS:    r_cfg.emergency_exit_ms    <= i_cfg_wr_data;
                CFG_STOP_GO_HOLD_MS:      r_cfg.stop_go_hold_ms      <= i_cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/slms_mode_fsm.sv =====
// Planner mode state machine with its wait timestamps.
// Depends on slms_pkg for mode and colour codes and the item types.
`timescale 1ns / 1ps

module slms_mode_fsm (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  slms_pkg::t_cfg      i_cfg,
    input  slms_pkg::t_in_item  i_item,
    output slms_pkg::t_out_item o_result
);
    import slms_pkg::*;

    typedef enum logic [3:0] {
        S_DRIVING      = MODE_DRIVING,
        S_TL_NEAR      = MODE_TL_NEAR,
        S_TL_GO        = MODE_TL_GO,
        S_TL_WILL_STOP = MODE_TL_WILL_STOP,
        S_TL_SLOW_DOWN = MODE_TL_SLOW_DOWN,
        S_TL_WAITING   = MODE_TL_WAITING,
        S_ST_NEAR      = MODE_ST_NEAR,
        S_ST_WILL_STOP = MODE_ST_WILL_STOP,
        S_ST_WAITING   = MODE_ST_WAITING,
        S_ST_GO        = MODE_ST_GO
    } t_mode;

    t_mode       r_mode, n_mode;
    logic [31:0] r_stop_wait_since, n_stop_wait_since;
    logic [31:0] r_blind_since, n_blind_since;
    logic        r_blind_valid, n_blind_valid;
    logic [31:0] r_go_since, n_go_since;
    logic        r_go_valid, n_go_valid;

    logic               w_line_lt_brake, w_line_le_brake;
    logic               w_line_lt_gap, w_line_le_gap;
    logic               w_fast, w_slow_lt, w_slow_le;
    logic signed [15:0] w_leave_s, w_still_s;
    logic [31:0]        w_stop_wait_el, w_go_el, w_blind_el, w_blind_since_nx;
    logic               w_col_unknown, w_col_red, w_col_yellow, w_col_green;
    logic               w_go_done, w_blind_exit, w_stop_wait_done;

    // Distance and speed compares; thresholds are non-negative signed values
    assign w_leave_s       = $signed({1'b0, i_cfg.leave_go_speed});
    assign w_still_s       = $signed({1'b0, i_cfg.standstill_speed});
    assign w_line_lt_brake = i_item.stop_line_distance <  i_item.braking_distance;
    assign w_line_le_brake = i_item.stop_line_distance <= i_item.braking_distance;
    assign w_line_lt_gap   = i_item.stop_line_distance <  i_cfg.min_stop_line_gap;
    assign w_line_le_gap   = i_item.stop_line_distance <= i_cfg.min_stop_line_gap;
    assign w_fast          = i_item.speed >  w_leave_s;
    assign w_slow_lt       = i_item.speed <  w_still_s;
    assign w_slow_le       = i_item.speed <= w_still_s;

    assign w_col_unknown = i_item.light_colour == COLOUR_UNKNOWN;
    assign w_col_red     = i_item.light_colour == COLOUR_RED;
    assign w_col_yellow  = i_item.light_colour == COLOUR_YELLOW;
    assign w_col_green   = i_item.light_colour == COLOUR_GREEN;

    // Elapsed times, wrapping modulo 2^32
    assign w_stop_wait_el   = i_item.now_ms - r_stop_wait_since;
    assign w_go_el          = i_item.now_ms - r_go_since;
    assign w_stop_wait_done = i_item.crossing_clear && w_slow_le &&
                              (w_stop_wait_el > i_cfg.stop_wait_ms);
    assign w_go_done        = w_fast && r_go_valid && (w_go_el >= i_cfg.stop_go_hold_ms);

    // Blind wait: keep a held start, take now when the colour is unknown and none is held
    assign w_blind_since_nx = (w_col_unknown && !r_blind_valid) ? i_item.now_ms
                                                                : r_blind_since;
    assign w_blind_el       = i_item.now_ms - w_blind_since_nx;
    assign w_blind_exit     = w_col_unknown && i_item.crossing_clear &&
                              (w_blind_el >= i_cfg.emergency_exit_ms);

    // Transition logic for the full and the reduced rule sets
    always_comb begin
        n_mode            = r_mode;
        n_stop_wait_since = r_stop_wait_since;
        n_blind_since     = r_blind_since;
        n_blind_valid     = r_blind_valid;
        n_go_since        = r_go_since;
        n_go_valid        = r_go_valid;
        if (!i_cfg.ignore_traffic_rules) begin
            unique case (r_mode)
                S_DRIVING: begin
                    if (i_item.light_seen)     n_mode = S_TL_NEAR;
                    else if (i_item.stop_seen) n_mode = S_ST_NEAR;
                end
                S_TL_NEAR: begin
                    if (w_col_green && w_line_lt_brake)              n_mode = S_TL_GO;
                    else if (w_col_red && w_line_lt_brake)           n_mode = S_TL_WILL_STOP;
                    else if (w_col_red)                              n_mode = S_TL_SLOW_DOWN;
                    else if (w_col_yellow)                           n_mode = S_TL_WILL_STOP;
                    else if (i_item.stop_seen && w_col_unknown)      n_mode = S_DRIVING;
                end
                S_TL_GO: begin
                    if (w_fast && (w_col_unknown || w_col_red)) n_mode = S_DRIVING;
                end
                S_TL_WILL_STOP: begin
                    if (w_col_green)                       n_mode = S_TL_GO;
                    else if (w_line_lt_gap || w_slow_lt)   n_mode = S_TL_WAITING;
                end
                S_TL_SLOW_DOWN: begin
                    if (w_col_green)                         n_mode = S_TL_GO;
                    else if (w_col_red && w_line_le_brake)   n_mode = S_TL_WILL_STOP;
                end
                S_TL_WAITING: begin
                    n_blind_since = w_blind_since_nx;
                    n_blind_valid = w_col_unknown;
                    if (w_col_green || w_blind_exit) n_mode = S_TL_GO;
                end
                S_ST_NEAR: begin
                    if (w_line_le_brake)        n_mode = S_ST_WILL_STOP;
                    else if (i_item.light_seen) n_mode = S_DRIVING;
                end
                S_ST_WILL_STOP: begin
                    if (w_line_le_gap) begin
                        n_mode            = S_ST_WAITING;
                        n_stop_wait_since = i_item.now_ms;
                    end
                end
                S_ST_WAITING: begin
                    if (w_stop_wait_done) begin
                        n_mode     = S_ST_GO;
                        n_go_since = i_item.now_ms;
                        n_go_valid = 1'b1;
                    end
                end
                S_ST_GO: begin
                    if (w_go_done) n_mode = S_DRIVING;
                end
                default: begin
                end
            endcase
        end else begin
            unique case (r_mode)
                S_DRIVING: begin
                    if (i_item.light_seen || i_item.stop_seen) n_mode = S_ST_NEAR;
                end
                S_TL_NEAR, S_TL_GO, S_TL_WILL_STOP, S_TL_SLOW_DOWN, S_TL_WAITING: begin
                    n_mode = S_DRIVING;
                end
                S_ST_NEAR: begin
                    if (w_line_le_brake) n_mode = S_ST_WILL_STOP;
                end
                S_ST_WILL_STOP: begin
                    if (w_line_le_gap) n_mode = S_ST_WAITING;
                end
                S_ST_WAITING: begin
                    if (i_item.crossing_clear) begin
                        n_mode     = S_ST_GO;
                        n_go_since = i_item.now_ms;
                        n_go_valid = 1'b1;
                    end
                end
                S_ST_GO: begin
                    if (w_go_done) n_mode = S_DRIVING;
                end
                default: begin
                end
            endcase
        end
    end

    // Advance the mode and timestamps once per processed transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode            <= S_DRIVING;
            r_stop_wait_since <= '0;
            r_blind_since     <= '0;
            r_blind_valid     <= 1'b0;
            r_go_since        <= '0;
            r_go_valid        <= 1'b0;
        end else if (i_step) begin
            r_mode            <= n_mode;
            r_stop_wait_since <= n_stop_wait_since;
            r_blind_since     <= n_blind_since;
            r_blind_valid     <= n_blind_valid;
            r_go_since        <= n_go_since;
            r_go_valid        <= n_go_valid;
        end
    end

    // Result of this transaction
    assign o_result.mode           = n_mode;
    assign o_result.in_light_group = !i_cfg.ignore_traffic_rules &&
                                     (n_mode >= S_TL_NEAR) && (n_mode <= S_TL_WAITING);
    assign o_result.in_stop_group  = (n_mode >= S_ST_NEAR) && (n_mode <= S_ST_GO);
    assign o_result.mode_changed   = n_mode != r_mode;

endmodule

// ===== rtl/core/stop_and_light_mode_sequencer.sv =====
// The input register takes a transaction at the edge that accepts it; the mode update and
// the result register take it from there once the result slot is free, and a full result
// stage holds it in the input register. Throughput: one transaction per cycle while the
// output is not stalled; the input register takes one more transaction while a finished
// result waits for i_out_ready. Reset (synchronous, active low): mode DRIVING, timestamps
// zero, wait starts invalid, configuration at defaults, both stages empty.
`timescale 1ns / 1ps

module stop_and_light_mode_sequencer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [slms_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [slms_pkg::CFG_DATA_W-1:0]  i_cfg_wr_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  slms_pkg::t_in_item               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output slms_pkg::t_out_item              o_out_data
);
    import slms_pkg::*;
    `include "assert_macros.svh"

    t_cfg      w_cfg;
    t_in_item  r_in_item;
    logic      r_in_valid;
    t_out_item r_out_item;
    logic      r_out_valid;
    t_out_item w_result;
    logic      w_advance;

    // Configuration registers
    slms_cfg_regs u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_cfg         (w_cfg)
    );

    // Mode update works on the registered input transaction
    slms_mode_fsm u_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_advance),
        .i_cfg    (w_cfg),
        .i_item   (r_in_item),
        .o_result (w_result)
    );

    // Move the input stage into the result stage when the result slot frees up
    assign w_advance  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_advance;

    // Stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) r_in_valid <= i_in_valid;
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) r_in_item  <= i_in_data;
        if (w_advance)                r_out_item <= w_result;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    `SLMS_ASSERT_NEXT(a_advance_fills_out, i_clk, i_rst_n, w_advance, r_out_valid,
        "processed transaction did not reach the result stage")
    `SLMS_ASSERT_NEXT(a_input_held, i_clk, i_rst_n, r_in_valid && !w_advance,
        r_in_valid && $stable(r_in_item), "waiting input transaction was lost")
    `SLMS_ASSERT(a_groups_exclusive, i_clk, i_rst_n,
        !(r_out_valid && r_out_item.in_light_group && r_out_item.in_stop_group),
        "result is in both the light and the stop group")
    `SLMS_ASSERT(a_stop_group_mode, i_clk, i_rst_n,
        !(r_out_valid && r_out_item.in_stop_group) ||
        (r_out_item.mode >= MODE_ST_NEAR && r_out_item.mode <= MODE_ST_GO),
        "stop group flag disagrees with mode")

endmodule

// ===== verif/stop_and_light_mode_sequencer_tb.sv =====
// Self-checking testbench of the stop-and-light mode sequencer: planning ticks are driven
// through valid/ready, each result is checked against a cycle-free mode predictor.
// Depends on slms_pkg and stop_and_light_mode_sequencer.
`timescale 1ns / 1ps

module stop_and_light_mode_sequencer_tb;
    import slms_pkg::*;

    localparam int N_PHASES      = 8;
    localparam int TICKS_PER_SET = 115;
    localparam int HOLD_AT       = 60;
    localparam int HOLD_CYCLES   = 80;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wr_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_data;

    stop_and_light_mode_sequencer uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_data    (o_out_data)
    );

    // Ticks waiting to be sent and results waiting to arrive
    t_in_item  tick_q[$];
    t_out_item mode_expect_q[$];
    t_out_item want_res;

    int   n_ticks_sent  = 0;
    int   n_ticks_taken = 0;
    int   n_results     = 0;
    int   n_errors      = 0;
    int   idle_in_pct   = 0;
    int   stall_out_pct = 0;
    int   hold_left     = 0;
    bit   hold_fired    = 1'b0;
    bit   in_taken      = 1'b0;
    logic [31:0] clock_ms = '0;
    logic [15:0] modes_seen = '0;

    // Shadow copy of the registers and the planner state
    t_cfg        cfg_now = '{1'b0, RST_LEAVE_GO_SPEED, RST_STANDSTILL_SPEED,
                             RST_MIN_STOP_LINE_GAP, RST_STOP_WAIT_MS,
                             RST_EMERGENCY_EXIT_MS, RST_STOP_GO_HOLD_MS};
    logic [3:0]  plan_mode    = MODE_DRIVING;
    logic [31:0] stop_wait_t0 = '0;
    logic [31:0] blind_t0     = '0;
    logic        blind_armed  = 1'b0;
    logic [31:0] go_t0        = '0;
    logic        go_armed     = 1'b0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Advance the planner by one tick and return the result it must produce
    function automatic t_out_item predict_tick(t_in_item it);
        logic [3:0] nxt;
        int         spd;
        int         go_thr;
        int         still_thr;
        logic       go_done;
        t_out_item  res;
        spd       = int'(it.speed);
        go_thr    = int'(cfg_now.leave_go_speed);
        still_thr = int'(cfg_now.standstill_speed);
        go_done   = spd > go_thr && go_armed &&
                    (it.now_ms - go_t0) >= cfg_now.stop_go_hold_ms;
        nxt = plan_mode;
        if (cfg_now.ignore_traffic_rules) begin
            // Reduced set: every light state falls back to driving
            case (plan_mode)
                MODE_DRIVING: if (it.light_seen || it.stop_seen) nxt = MODE_ST_NEAR;
                MODE_TL_NEAR, MODE_TL_GO, MODE_TL_WILL_STOP, MODE_TL_SLOW_DOWN,
                MODE_TL_WAITING: nxt = MODE_DRIVING;
                MODE_ST_NEAR: if (it.stop_line_distance <= it.braking_distance)
                    nxt = MODE_ST_WILL_STOP;
                MODE_ST_WILL_STOP: if (it.stop_line_distance <= cfg_now.min_stop_line_gap)
                    nxt = MODE_ST_WAITING;
                MODE_ST_WAITING: if (it.crossing_clear) begin
                    nxt = MODE_ST_GO;
                    go_t0 = it.now_ms;
                    go_armed = 1'b1;
                end
                MODE_ST_GO: if (go_done) nxt = MODE_DRIVING;
                default: ;
            endcase
        end else begin
            case (plan_mode)
                MODE_DRIVING: begin
                    if (it.light_seen) nxt = MODE_TL_NEAR;
                    else if (it.stop_seen) nxt = MODE_ST_NEAR;
                end
                MODE_TL_NEAR: begin
                    if (it.light_colour == COLOUR_GREEN &&
                        it.stop_line_distance < it.braking_distance) nxt = MODE_TL_GO;
                    else if (it.light_colour == COLOUR_RED &&
                             it.stop_line_distance < it.braking_distance)
                        nxt = MODE_TL_WILL_STOP;
                    else if (it.light_colour == COLOUR_RED) nxt = MODE_TL_SLOW_DOWN;
                    else if (it.light_colour == COLOUR_YELLOW) nxt = MODE_TL_WILL_STOP;
                    else if (it.stop_seen && it.light_colour == COLOUR_UNKNOWN)
                        nxt = MODE_DRIVING;
                end
                MODE_TL_GO: begin
                    if (spd > go_thr && (it.light_colour == COLOUR_UNKNOWN ||
                                         it.light_colour == COLOUR_RED))
                        nxt = MODE_DRIVING;
                end
                MODE_TL_WILL_STOP: begin
                    if (it.light_colour == COLOUR_GREEN) nxt = MODE_TL_GO;
                    else if (it.stop_line_distance < cfg_now.min_stop_line_gap ||
                             spd < still_thr) nxt = MODE_TL_WAITING;
                end
                MODE_TL_SLOW_DOWN: begin
                    if (it.light_colour == COLOUR_GREEN) nxt = MODE_TL_GO;
                    else if (it.light_colour == COLOUR_RED &&
                             it.stop_line_distance <= it.braking_distance)
                        nxt = MODE_TL_WILL_STOP;
                end
                MODE_TL_WAITING: begin
                    if (it.light_colour == COLOUR_GREEN) nxt = MODE_TL_GO;
                    // Keep a held blind-wait start; a known colour drops it
                    if (it.light_colour == COLOUR_UNKNOWN) begin
                        if (!blind_armed) begin
                            blind_t0 = it.now_ms;
                            blind_armed = 1'b1;
                        end
                    end else begin
                        blind_armed = 1'b0;
                    end
                    if (blind_armed && it.crossing_clear &&
                        (it.now_ms - blind_t0) >= cfg_now.emergency_exit_ms)
                        nxt = MODE_TL_GO;
                end
                MODE_ST_NEAR: begin
                    if (it.stop_line_distance <= it.braking_distance) nxt = MODE_ST_WILL_STOP;
                    else if (it.light_seen) nxt = MODE_DRIVING;
                end
                MODE_ST_WILL_STOP: begin
                    if (it.stop_line_distance <= cfg_now.min_stop_line_gap) begin
                        nxt = MODE_ST_WAITING;
                        stop_wait_t0 = it.now_ms;
                    end
                end
                MODE_ST_WAITING: begin
                    if (it.crossing_clear && (it.now_ms - stop_wait_t0) > cfg_now.stop_wait_ms &&
                        spd <= still_thr) begin
                        nxt = MODE_ST_GO;
                        go_t0 = it.now_ms;
                        go_armed = 1'b1;
                    end
                end
                MODE_ST_GO: if (go_done) nxt = MODE_DRIVING;
                default: ;
            endcase
        end
        res.mode           = nxt;
        res.in_light_group = !cfg_now.ignore_traffic_rules &&
                             nxt >= MODE_TL_NEAR && nxt <= MODE_TL_WAITING;
        res.in_stop_group  = nxt >= MODE_ST_NEAR && nxt <= MODE_ST_GO;
        res.mode_changed   = nxt != plan_mode;
        plan_mode = nxt;
        modes_seen[nxt] = 1'b1;
        return res;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            n_errors++;
            $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    // Monitor: check results, then log the transaction accepted on the input side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_taken = 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (mode_expect_q.size() == 0) begin
                    n_errors++;
                    $error("result with no tick pending: mode %0d", o_out_data.mode);
                end else begin
                    want_res = mode_expect_q.pop_front();
                    check_field("mode", 32'(want_res.mode), 32'(o_out_data.mode));
                    check_field("in_light_group", 32'(want_res.in_light_group),
                                32'(o_out_data.in_light_group));
                    check_field("in_stop_group", 32'(want_res.in_stop_group),
                                32'(o_out_data.in_stop_group));
                    check_field("mode_changed", 32'(want_res.mode_changed),
                                32'(o_out_data.mode_changed));
                end
                n_results++;
            end
            in_taken = i_in_valid && o_in_ready;
            if (in_taken) begin
                mode_expect_q.push_back(predict_tick(i_in_data));
                n_ticks_taken++;
            end
        end
    end

    // Driver: hold the transaction until taken, then offer the next one or idle
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            if (tick_q.size() != 0 && $urandom_range(99) >= idle_in_pct) begin
                i_in_valid <= 1'b1;
                i_in_data  <= tick_q.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus one long hold-off to back the block up
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (!hold_fired && n_ticks_taken >= HOLD_AT) begin
            hold_fired = 1'b1;
            hold_left = HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= stall_out_pct);
        end
    end

    function automatic bit chance(int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic logic [1:0] pick_colour();
        int roll;
        roll = $urandom_range(99);
        if (roll < 40) return COLOUR_RED;
        if (roll < 60) return COLOUR_YELLOW;
        if (roll < 80) return COLOUR_GREEN;
        return COLOUR_UNKNOWN;
    endfunction

    function automatic int some_speed();
        if (chance(10)) return int'($urandom_range(65535)) - 32768;
        return int'($urandom_range(400)) - 50;
    endfunction

    // Queue one tick, advancing the millisecond clock by dt
    function automatic void push_tick(bit light, bit stop, logic [1:0] colour, int brake,
                                      int speed, int line, bit clear, logic [31:0] dt);
        t_in_item it;
        clock_ms = clock_ms + dt;
        it.light_seen         = light;
        it.stop_seen          = stop;
        it.light_colour       = colour;
        it.braking_distance   = brake[15:0];
        it.speed              = speed[15:0];
        it.stop_line_distance = line[15:0];
        it.crossing_clear     = clear;
        it.now_ms             = clock_ms;
        tick_q.push_back(it);
        n_ticks_sent++;
    endfunction

    // Approach a light: near, colour seen, stop, wait (mostly blind), leave
    function automatic void queue_light_run();
        int brake;
        brake = $urandom_range(600, 40);
        push_tick(1'b1, chance(20), pick_colour(), brake, some_speed(),
                  brake + $urandom_range(400), chance(50), $urandom_range(800, 50));
        repeat ($urandom_range(3, 1))
            push_tick(chance(50), chance(10), pick_colour(), brake, some_speed(),
                      $urandom_range(2 * brake), chance(50), $urandom_range(800, 50));
        repeat ($urandom_range(2, 1))
            push_tick(chance(30), chance(10), chance(85) ? COLOUR_RED : pick_colour(), brake,
                      int'($urandom_range(80)) - 20, $urandom_range(300), chance(50),
                      $urandom_range(800, 50));
        repeat ($urandom_range(8, 2))
            push_tick(chance(30), chance(10), chance(80) ? COLOUR_UNKNOWN : pick_colour(),
                      brake, int'($urandom_range(40)) - 20, $urandom_range(300), chance(75),
                      $urandom_range(4000, 500));
        repeat ($urandom_range(3, 1))
            push_tick(chance(20), chance(10), pick_colour(), brake, $urandom_range(400),
                      $urandom_range(65535), chance(50), $urandom_range(1000, 50));
    endfunction

    // Approach a stop sign: near, will stop, arrive, wait at standstill, go
    function automatic void queue_stop_run();
        int brake;
        brake = $urandom_range(600, 40);
        push_tick(chance(15), 1'b1, pick_colour(), brake, some_speed(),
                  brake + $urandom_range(400), chance(50), $urandom_range(800, 50));
        push_tick(chance(15), chance(50), pick_colour(), brake, some_speed(),
                  $urandom_range(brake), chance(50), $urandom_range(800, 50));
        repeat ($urandom_range(3, 1))
            push_tick(chance(15), chance(50), pick_colour(), brake, some_speed(),
                      $urandom_range(400), chance(50), $urandom_range(800, 50));
        repeat ($urandom_range(6, 2))
            push_tick(chance(15), chance(30), pick_colour(), brake,
                      int'($urandom_range(60)) - 30, $urandom_range(300), chance(70),
                      $urandom_range(2500, 300));
        repeat ($urandom_range(5, 2))
            push_tick(chance(15), chance(30), pick_colour(), brake, $urandom_range(400),
                      $urandom_range(65535), chance(50), $urandom_range(1500, 200));
    endfunction

    function automatic void queue_noise_tick();
        push_tick(chance(50), chance(50), 2'($urandom_range(3)), $urandom_range(65535),
                  int'($urandom_range(65535)) - 32768, $urandom_range(65535), chance(50),
                  chance(3) ? $urandom() : $urandom_range(3000));
    endfunction

    // Walk both routes with default registers, through timer edges and the wrap of now_ms
    function automatic void queue_directed();
        push_tick(1'b0, 1'b0, COLOUR_UNKNOWN, 0, 0, 0, 1'b0, 32'd0);
        push_tick(1'b1, 1'b1, COLOUR_GREEN, 65535, -1, 65535, 1'b1, 32'hFFFF_FFFF);
        push_tick(1'b0, 1'b0, COLOUR_RED, 500, 300, 100, 1'b0, 32'd10);
        push_tick(1'b0, 1'b0, COLOUR_RED, 0, -32768, 65535, 1'b0, 32'd10);
        // Blind wait: start taken, then the emergency exit after the wrap
        push_tick(1'b0, 1'b0, COLOUR_UNKNOWN, 0, 0, 0, 1'b1, 32'd1000);
        push_tick(1'b0, 1'b0, COLOUR_UNKNOWN, 0, 0, 0, 1'b0, 32'd5000);
        push_tick(1'b0, 1'b0, COLOUR_UNKNOWN, 0, 0, 0, 1'b1, 32'd6000);
        push_tick(1'b0, 1'b0, COLOUR_RED, 0, 32767, 0, 1'b0, 32'd10);
        // Stop sign: wait exactly at the limit, then one past it; hold the go state
        push_tick(1'b0, 1'b1, COLOUR_UNKNOWN, 0, 0, 1000, 1'b0, 32'd10);
        push_tick(1'b0, 1'b0, COLOUR_UNKNOWN, 0, 0, 0, 1'b0, 32'd10);
        push_tick(1'b0, 1'b0, COLOUR_UNKNOWN, 0, 0, 200, 1'b0, 32'd10);
        push_tick(1'b0, 1'b0, COLOUR_UNKNOWN, 0, 10, 0, 1'b1, 32'd3000);
        push_tick(1'b0, 1'b0, COLOUR_UNKNOWN, 0, 10, 0, 1'b1, 32'd1);
        push_tick(1'b0, 1'b0, COLOUR_UNKNOWN, 0, 101, 0, 1'b1, 32'd1999);
        push_tick(1'b0, 1'b0, COLOUR_UNKNOWN, 0, 100, 0, 1'b1, 32'd1);
        push_tick(1'b0, 1'b0, COLOUR_UNKNOWN, 0, 101, 0, 1'b1, 32'd0);
        // Yellow and green through the light states
        push_tick(1'b1, 1'b0, COLOUR_UNKNOWN, 0, 0, 0, 1'b0, 32'd10);
        push_tick(1'b0, 1'b0, COLOUR_YELLOW, 0, 0, 1000, 1'b0, 32'd10);
        push_tick(1'b0, 1'b0, COLOUR_GREEN, 0, 0, 1000, 1'b0, 32'd10);
        push_tick(1'b0, 1'b0, COLOUR_GREEN, 0, 200, 0, 1'b0, 32'd10);
        push_tick(1'b0, 1'b0, COLOUR_UNKNOWN, 0, 200, 0, 1'b0, 32'd10);
        // Slow down, then a wait that reuses the blind start left from before
        push_tick(1'b1, 1'b0, COLOUR_UNKNOWN, 0, 0, 0, 1'b0, 32'd10);
        push_tick(1'b0, 1'b0, COLOUR_RED, 100, 300, 500, 1'b0, 32'd10);
        push_tick(1'b0, 1'b0, COLOUR_RED, 100, 300, 100, 1'b0, 32'd10);
        push_tick(1'b0, 1'b0, COLOUR_RED, 100, 50, 0, 1'b0, 32'd10);
        push_tick(1'b0, 1'b0, COLOUR_UNKNOWN, 0, 0, 0, 1'b1, 32'd10);
    endfunction

    function automatic t_cfg pick_setting(int phase);
        t_cfg s;
        case (phase)
            0, 3: s = '{1'b0, RST_LEAVE_GO_SPEED, RST_STANDSTILL_SPEED,
                        RST_MIN_STOP_LINE_GAP, RST_STOP_WAIT_MS,
                        RST_EMERGENCY_EXIT_MS, RST_STOP_GO_HOLD_MS};
            1, 6: s = '0;
            2, 5: s = '1;
            default: begin
                s.leave_go_speed    = 15'($urandom_range(300));
                s.standstill_speed  = 15'($urandom_range(60));
                s.min_stop_line_gap = 16'($urandom_range(400));
                s.stop_wait_ms      = $urandom_range(6000);
                s.emergency_exit_ms = $urandom_range(15000);
                s.stop_go_hold_ms   = $urandom_range(4000);
            end
        endcase
        s.ignore_traffic_rules = (phase == 7) ? 1'($urandom_range(1)) :
                                                (phase >= 3 && phase != 4);
        return s;
    endfunction

    task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_addr    <= addr;
        i_cfg_wr_data <= data;
        case (addr)
            CFG_IGNORE_TRAFFIC_RULES: cfg_now.ignore_traffic_rules = data[0];
            CFG_LEAVE_GO_SPEED:       cfg_now.leave_go_speed       = data[14:0];
            CFG_STANDSTILL_SPEED:     cfg_now.standstill_speed     = data[14:0];
            CFG_MIN_STOP_LINE_GAP:    cfg_now.min_stop_line_gap    = data[15:0];
            CFG_STOP_WAIT_MS:         cfg_now.stop_wait_ms         = data;
            CFG_EMERGENCY_EXIT_MS:    cfg_now.emergency_exit_ms    = data;
            CFG_STOP_GO_HOLD_MS:      cfg_now.stop_go_hold_ms      = data;
            default: ;
        endcase
    endtask

    task automatic apply_settings(t_cfg s);
        cfg_write(CFG_IGNORE_TRAFFIC_RULES, {31'd0, s.ignore_traffic_rules});
        cfg_write(CFG_LEAVE_GO_SPEED, {17'd0, s.leave_go_speed});
        cfg_write(CFG_STANDSTILL_SPEED, {17'd0, s.standstill_speed});
        cfg_write(CFG_MIN_STOP_LINE_GAP, {16'd0, s.min_stop_line_gap});
        cfg_write(CFG_STOP_WAIT_MS, s.stop_wait_ms);
        cfg_write(CFG_EMERGENCY_EXIT_MS, s.emergency_exit_ms);
        cfg_write(CFG_STOP_GO_HOLD_MS, s.stop_go_hold_ms);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Wait until every tick is taken and every result checked, plus the pipeline depth
    task automatic wait_drained();
        while (n_ticks_taken != n_ticks_sent || mode_expect_q.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Stimulus: one register setting and idling pattern per phase
    initial begin
        t_cfg setting;
        int   target;
        int   roll;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int phase = 0; phase < N_PHASES; phase++) begin
            wait_drained();
            case (phase % 4)
                0: begin idle_in_pct = 0;  stall_out_pct = 0;  end
                1: begin idle_in_pct = 73; stall_out_pct = 0;  end
                2: begin idle_in_pct = 0;  stall_out_pct = 73; end
                default: begin idle_in_pct = 17; stall_out_pct = 17; end
            endcase
            setting = pick_setting(phase);
            apply_settings(setting);
            if (phase == 0) queue_directed();
            target = n_ticks_sent + TICKS_PER_SET;
            while (n_ticks_sent < target) begin
                roll = $urandom_range(99);
                if (roll < 40) queue_light_run();
                else if (roll < 75) queue_stop_run();
                else repeat ($urandom_range(4, 1)) queue_noise_tick();
            end
        end
        wait_drained();
        repeat (8) @(posedge i_clk);
        $display("Checked %0d results from %0d ticks over %0d register settings",
                 n_results, n_ticks_taken, N_PHASES);
        $display("Planner modes reached (bit per code): %b", modes_seen);
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== stop_and_light_mode_sequencer.f =====
+incdir+rtl/core
rtl/core/slms_pkg.sv
rtl/core/slms_cfg_regs.sv
rtl/core/slms_mode_fsm.sv
rtl/core/stop_and_light_mode_sequencer.sv
verif/stop_and_light_mode_sequencer_tb.sv
